/* sv/bcd_pkg.sv */
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared types and constants for the bounded circular deque.
// ----------------------------------------------------------------------------
package bcd_pkg;

  localparam int DefDepth = 1024;
  localparam int ValW     = 32;
  localparam int OpW      = 3;
  localparam int CapW     = 11;
  localparam logic [CapW-1:0] CapReset = 11'd1024;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_QUERY      = 3'd4
  } bcd_op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } bcd_state_e;

endpackage

/* sv/bcd_if.sv */
// ----------------------------------------------------------------------------
// bcd_if
// Valid/ready channels for deque commands and deque results.
// ----------------------------------------------------------------------------
interface bcd_in_if
  import bcd_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [OpW-1:0]         opcode;
  logic signed [ValW-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface bcd_out_if
  import bcd_pkg::*;
#(
  parameter int CntW = 11
) ();
  logic                   valid;
  logic                   ready;
  logic                   ok;
  logic signed [ValW-1:0] front_value;
  logic signed [ValW-1:0] rear_value;
  logic                   empty_res;
  logic                   full_res;
  logic [CntW-1:0]        count;

  modport source (output valid, output ok, output front_value, output rear_value,
                  output empty_res, output full_res, output count, input ready);
  modport sink   (input valid, input ok, input front_value, input rear_value,
                  input empty_res, input full_res, input count, output ready);
endinterface

/* sv/bounded_circular_deque.sv */
// ----------------------------------------------------------------------------
// bounded_circular_deque
// Bounded double-ended queue of signed 32-bit words in a ring memory.
// ----------------------------------------------------------------------------
// Each command word pushes at the front or back, pops from the front or
// back, or just queries; every command returns exactly one result word with
// ok, front/rear words (zero when empty), empty/full flags and the count
// after the command. A push on a full deque or a pop on an empty one returns
// ok = 0 and changes nothing; opcodes 5 to 7 act as a query. Pushes, queries,
// refused commands and pops that empty the deque load the result register on
// acceptance; a pop that leaves words behind goes through the read state
// first, since the new front or rear word is registered ring memory data.
// The result register lets a new command enter while the previous result is
// taken. The capacity register (reset 1024) is clipped to DEPTH; zero makes
// the deque both empty and full. Lowering it below the current count only
// blocks pushes. No clearing pass: entries are read only after being written.
// ----------------------------------------------------------------------------
module bounded_circular_deque
  import bcd_pkg::*;
#(
  parameter int DEPTH = DefDepth,
  parameter int PtrW  = $clog2(DEPTH),
  parameter int CntW  = $clog2(DEPTH + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i,
  bcd_in_if.sink          in_i,
  bcd_out_if.source       out_o
);

  // compare width covers both the count and the capacity register
  localparam int EW = (CntW > CapW) ? CntW : CapW;

  logic [CapW-1:0] cap_q;
  logic [EW-1:0]   cap_ext, cap_eff;

  logic            mem_we, mem_re;
  logic [PtrW-1:0] mem_waddr, mem_raddr;
  logic [ValW-1:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // clip to the ring size
  assign cap_ext = EW'(cap_q);
  assign cap_eff = (cap_ext > EW'(DEPTH)) ? EW'(DEPTH) : cap_ext;

  bcd_ctrl #(
    .DEPTH (DEPTH),
    .PtrW  (PtrW),
    .CntW  (CntW),
    .EW    (EW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_eff_i   (cap_eff),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  bcd_ring_mem #(
    .DEPTH (DEPTH),
    .PtrW  (PtrW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

/* sv/bcd_ring_mem.sv */
// ----------------------------------------------------------------------------
// bcd_ring_mem
// Ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bcd_ring_mem
  import bcd_pkg::*;
#(
  parameter int DEPTH = DefDepth,
  parameter int PtrW  = $clog2(DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [PtrW-1:0]        waddr_i,
  input  logic [ValW-1:0]        wdata_i,
  input  logic                   re_i,
  input  logic [PtrW-1:0]        raddr_i,
  output logic [ValW-1:0]        rdata_o
);

  logic [ValW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* sv/bcd_ctrl.sv */
// ----------------------------------------------------------------------------
// bcd_ctrl
// Pointer and count update, front/rear word tracking, result register.
// ----------------------------------------------------------------------------
module bcd_ctrl
  import bcd_pkg::*;
#(
  parameter int DEPTH = DefDepth,
  parameter int PtrW  = $clog2(DEPTH),
  parameter int CntW  = $clog2(DEPTH + 1),
  parameter int EW    = (CntW > CapW) ? CntW : CapW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [EW-1:0]   cap_eff_i,
  bcd_in_if.sink          in_i,
  bcd_out_if.source       out_o,
  output logic            mem_we_o,
  output logic [PtrW-1:0] mem_waddr_o,
  output logic [ValW-1:0] mem_wdata_o,
  output logic            mem_re_o,
  output logic [PtrW-1:0] mem_raddr_o,
  input  logic [ValW-1:0] mem_rdata_i
);

  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);

  bcd_state_e      st_q, st_d;
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [ValW-1:0] front_q, front_d, rear_q, rear_d;
  logic            rd_front_q, rd_front_d;
  logic            out_valid_q, out_valid_d;
  logic            acc, rd_need, ok_w, out_load, was_empty, was_full, now_empty;
  logic [PtrW-1:0] head_prev, head_next, tail_prev, tail_next, tail_prev2;

  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
    return (p == LastIdx) ? '0 : p + PtrW'(1);
  endfunction

  function automatic logic [PtrW-1:0] ring_prev(input logic [PtrW-1:0] p);
    return (p == '0) ? LastIdx : p - PtrW'(1);
  endfunction

  assign head_prev  = ring_prev(head_q);
  assign head_next  = ring_next(head_q);
  assign tail_prev  = ring_prev(tail_q);
  assign tail_next  = ring_next(tail_q);
  assign tail_prev2 = ring_prev(tail_prev);
  assign was_empty  = (cnt_q == '0);
  assign was_full   = (EW'(cnt_q) >= cap_eff_i);
  assign acc        = in_i.valid && in_i.ready;

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (acc && rd_need) st_d = ST_READ;
      ST_READ: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_i.ready = (st_q == ST_IDLE) && (!out_valid_q || out_o.ready);
    out_load   = (st_q == ST_READ) || (acc && !rd_need);
  end

  // datapath
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    front_d     = front_q;
    rear_d      = rear_q;
    rd_front_d  = rd_front_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = tail_q;
    mem_wdata_o = in_i.value;
    mem_re_o    = 1'b0;
    mem_raddr_o = head_next;
    ok_w        = 1'b1;
    rd_need     = 1'b0;
    if (st_q == ST_READ) begin
      if (rd_front_q) front_d = mem_rdata_i;
      else            rear_d  = mem_rdata_i;
    end else begin
      case (bcd_op_e'(in_i.opcode))
        OP_PUSH_FRONT: begin
          if (was_full) begin
            ok_w = 1'b0;
          end else if (acc) begin
            head_d      = head_prev;
            mem_we_o    = 1'b1;
            mem_waddr_o = head_prev;
            cnt_d       = cnt_q + CntW'(1);
            front_d     = in_i.value;
            if (was_empty) rear_d = in_i.value;
          end
        end
        OP_PUSH_REAR: begin
          if (was_full) begin
            ok_w = 1'b0;
          end else if (acc) begin
            tail_d      = tail_next;
            mem_we_o    = 1'b1;
            mem_waddr_o = tail_q;
            cnt_d       = cnt_q + CntW'(1);
            rear_d      = in_i.value;
            if (was_empty) front_d = in_i.value;
          end
        end
        OP_POP_FRONT: begin
          if (was_empty) begin
            ok_w = 1'b0;
          end else begin
            rd_need     = (cnt_q != CntW'(1));
            mem_raddr_o = head_next;
            if (acc) begin
              head_d     = head_next;
              cnt_d      = cnt_q - CntW'(1);
              mem_re_o   = rd_need;
              rd_front_d = 1'b1;
            end
          end
        end
        OP_POP_REAR: begin
          if (was_empty) begin
            ok_w = 1'b0;
          end else begin
            rd_need     = (cnt_q != CntW'(1));
            mem_raddr_o = tail_prev2;
            if (acc) begin
              tail_d     = tail_prev;
              cnt_d      = cnt_q - CntW'(1);
              mem_re_o   = rd_need;
              rd_front_d = 1'b0;
            end
          end
        end
        default: ;  // query, unused codes too
      endcase
    end
  end

  assign now_empty   = (cnt_d == '0);
  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);
  assign out_o.valid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      rd_front_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      rd_front_q  <= rd_front_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    rear_q  <= rear_d;
    if (out_load) begin
      out_o.ok          <= ok_w;
      out_o.front_value <= now_empty ? '0 : front_d;
      out_o.rear_value  <= now_empty ? '0 : rear_d;
      out_o.empty_res   <= now_empty;
      out_o.full_res    <= (EW'(cnt_d) >= cap_eff_i);
      out_o.count       <= cnt_d;
    end
  end

  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_READ |-> !out_valid_q) else $error("result slot busy during read");

  a_read_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_READ |-> $past(acc) && $past(mem_re_o)) else $error("stray read state");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o)) else $error("ring read and write in one cycle");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    EW'(cnt_q) <= EW'(DEPTH)) else $error("count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> head_q == tail_q) else $error("empty deque with split pointers");

endmodule
